@@ design/irkd_pkg.sv @@
// Shared types, key map and reset constants for the IR key dimmer controller.
// No dependencies; used by ir_key_dimmer_controller.
package irkd_pkg;

    typedef enum logic [2:0] {
        ACT_IGNORED = 3'd0,
        ACT_UNKNOWN = 3'd1,
        ACT_ALL_ON  = 3'd2,
        ACT_ALL_OFF = 3'd3,
        ACT_TOGGLE  = 3'd4,
        ACT_UP      = 3'd5,
        ACT_DOWN    = 3'd6
    } t_action;

    typedef enum logic [1:0] {
        CFG_UPDOWN_HOLD = 2'd0,
        CFG_SAME_HOLD   = 2'd1,
        CFG_OTHER_HOLD  = 2'd2,
        CFG_LEVEL_STEP  = 2'd3
    } t_cfg_reg;

    typedef struct packed {
        t_action    action;
        logic [2:0] slot;
    } t_key_class;

    localparam logic [7:0] KEY_ALL_ON    = 8'h45;
    localparam logic [7:0] KEY_ALL_OFF   = 8'h47;
    localparam logic [7:0] KEY_CH0_TOG   = 8'h44;
    localparam logic [7:0] KEY_CH0_UP    = 8'h40;
    localparam logic [7:0] KEY_CH0_DN    = 8'h43;
    localparam logic [7:0] KEY_CH1_TOG   = 8'h07;
    localparam logic [7:0] KEY_CH1_UP    = 8'h15;
    localparam logic [7:0] KEY_CH1_DN    = 8'h09;
    localparam logic [7:0] KEY_CH2_TOG   = 8'h16;
    localparam logic [7:0] KEY_CH2_UP    = 8'h19;
    localparam logic [7:0] KEY_CH2_DN    = 8'h0D;
    localparam logic [7:0] KEY_CH3_TOG   = 8'h0C;
    localparam logic [7:0] KEY_CH3_UP    = 8'h18;
    localparam logic [7:0] KEY_CH3_DN    = 8'h5E;
    localparam logic [7:0] KEY_CH4_TOG   = 8'h08;
    localparam logic [7:0] KEY_CH4_UP    = 8'h1C;
    localparam logic [7:0] KEY_CH4_DN    = 8'h5A;
    localparam logic [7:0] KEY_MST_TOG   = 8'h42;
    localparam logic [7:0] KEY_MST_UP    = 8'h52;
    localparam logic [7:0] KEY_MST_DN    = 8'h4A;

    localparam logic [2:0] MASTER_SLOT    = 3'd5;
    localparam logic [7:0] LEVEL_MIN      = 8'd1;
    localparam logic [7:0] LEVEL_MAX      = 8'd254;
    localparam logic [7:0] LAST_KEY_RESET = 8'hFF;

    localparam logic [15:0] UPDOWN_HOLD_RESET = 16'd100;
    localparam logic [15:0] SAME_HOLD_RESET   = 16'd500;
    localparam logic [15:0] OTHER_HOLD_RESET  = 16'd250;
    localparam logic [7:0]  LEVEL_STEP_RESET  = 8'd12;

    function automatic t_key_class classify(input logic [7:0] key);
        t_key_class c;
        c.slot   = 3'd0;
        c.action = ACT_UNKNOWN;
        case (key)
            KEY_ALL_ON:  c.action = ACT_ALL_ON;
            KEY_ALL_OFF: c.action = ACT_ALL_OFF;
            KEY_CH0_TOG: begin c.action = ACT_TOGGLE; c.slot = 3'd0; end
            KEY_CH0_UP:  begin c.action = ACT_UP;     c.slot = 3'd0; end
            KEY_CH0_DN:  begin c.action = ACT_DOWN;   c.slot = 3'd0; end
            KEY_CH1_TOG: begin c.action = ACT_TOGGLE; c.slot = 3'd1; end
            KEY_CH1_UP:  begin c.action = ACT_UP;     c.slot = 3'd1; end
            KEY_CH1_DN:  begin c.action = ACT_DOWN;   c.slot = 3'd1; end
            KEY_CH2_TOG: begin c.action = ACT_TOGGLE; c.slot = 3'd2; end
            KEY_CH2_UP:  begin c.action = ACT_UP;     c.slot = 3'd2; end
            KEY_CH2_DN:  begin c.action = ACT_DOWN;   c.slot = 3'd2; end
            KEY_CH3_TOG: begin c.action = ACT_TOGGLE; c.slot = 3'd3; end
            KEY_CH3_UP:  begin c.action = ACT_UP;     c.slot = 3'd3; end
            KEY_CH3_DN:  begin c.action = ACT_DOWN;   c.slot = 3'd3; end
            KEY_CH4_TOG: begin c.action = ACT_TOGGLE; c.slot = 3'd4; end
            KEY_CH4_UP:  begin c.action = ACT_UP;     c.slot = 3'd4; end
            KEY_CH4_DN:  begin c.action = ACT_DOWN;   c.slot = 3'd4; end
            KEY_MST_TOG: begin c.action = ACT_TOGGLE; c.slot = MASTER_SLOT; end
            KEY_MST_UP:  begin c.action = ACT_UP;     c.slot = MASTER_SLOT; end
            KEY_MST_DN:  begin c.action = ACT_DOWN;   c.slot = MASTER_SLOT; end
            default:     c.action = ACT_UNKNOWN;
        endcase
        return c;
    endfunction

endpackage

@@ design/ir_key_dimmer_controller.sv @@
// IR key dimmer controller: debounce, key decode and channel on/level state.
// Depends on irkd_pkg for the action codes, key map and reset constants.
//
// Channel   Handshake                 Beat contents
// input     i_in_valid / o_in_stall   i_key_code, i_is_repeat, i_tick_time
// output    o_out_valid / i_out_stall o_accepted, o_action, o_channel, o_on_mask, o_level
// config    i_cfg_wr_en               i_cfg_index, i_cfg_data
//
// Each beat passes through the input register and leaves through the result
// register, so one beat per cycle is sustained while the output is not stalled.
// The debounce compares the tick difference against limits scaled to ticks when
// a hold register is written, so no division sits in the beat path.
// Reset is synchronous: all channels off at level 254, last key 0xFF at time 0.
// A stall on the output holds the result register and, once the input register
// is also full, raises o_in_stall.
module ir_key_dimmer_controller #(
    parameter int TICKS_PER_MS = 16000,
    parameter int NUM_CHANNELS = 6
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_wr_en,
    input  irkd_pkg::t_cfg_reg i_cfg_index,
    input  logic [15:0]        i_cfg_data,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [7:0]         i_key_code,
    input  logic               i_is_repeat,
    input  logic [31:0]        i_tick_time,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic               o_accepted,
    output irkd_pkg::t_action  o_action,
    output logic [2:0]         o_channel,
    output logic [5:0]         o_on_mask,
    output logic [7:0]         o_level
);
    import irkd_pkg::*;

    localparam int TICK_W = $clog2(TICKS_PER_MS + 1);
    localparam int TH_W   = 16 + TICK_W;
    localparam int CMP_W  = (TH_W > 32) ? TH_W : 32;
    localparam int IDX_W  = $clog2(NUM_CHANNELS);
    localparam int MASK_N = (NUM_CHANNELS < 6) ? NUM_CHANNELS : 6;
    localparam logic [2:0] MASTER_CH = 3'(NUM_CHANNELS - 1);
    localparam logic [TH_W-1:0] TICKS_K = TH_W'(TICKS_PER_MS);
    localparam logic [TH_W-1:0] UPDOWN_TH_RESET = TH_W'(UPDOWN_HOLD_RESET) * TICKS_K;
    localparam logic [TH_W-1:0] SAME_TH_RESET   = TH_W'(SAME_HOLD_RESET) * TICKS_K;
    localparam logic [TH_W-1:0] OTHER_TH_RESET  = TH_W'(OTHER_HOLD_RESET) * TICKS_K;

    logic [TH_W-1:0] r_updown_th;
    logic [TH_W-1:0] r_same_th;
    logic [TH_W-1:0] r_other_th;
    logic [7:0]      r_level_step;
    logic [TH_W-1:0] w_cfg_th;

    logic        r_in_valid;
    logic [7:0]  r_key_code;
    logic        r_is_repeat;
    logic [31:0] r_tick_time;

    logic       r_chan_on    [NUM_CHANNELS];
    logic [7:0] r_chan_level [NUM_CHANNELS];
    logic       n_chan_on    [NUM_CHANNELS];
    logic [7:0] n_chan_level [NUM_CHANNELS];
    logic [7:0]  r_last_key;
    logic [31:0] r_last_time;

    logic        r_out_valid;
    logic        r_accepted;
    t_action     r_action;
    logic [2:0]  r_channel;
    logic [5:0]  r_on_mask;
    logic [7:0]  r_level;

    logic             w_advance;
    t_key_class       w_class;
    logic             w_updn;
    logic [31:0]      w_delta;
    logic [TH_W-1:0]  w_limit;
    logic             w_acc;
    t_action          w_action;
    logic [2:0]       w_ch;
    logic [IDX_W-1:0] w_idx;
    logic signed [9:0] w_adj;
    logic [5:0]       w_mask;

    assign w_advance  = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !w_advance;
    assign w_cfg_th   = TH_W'(i_cfg_data) * TICKS_K;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_updown_th  <= UPDOWN_TH_RESET;
            r_same_th    <= SAME_TH_RESET;
            r_other_th   <= OTHER_TH_RESET;
            r_level_step <= LEVEL_STEP_RESET;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_UPDOWN_HOLD: r_updown_th  <= w_cfg_th;
                CFG_SAME_HOLD:   r_same_th    <= w_cfg_th;
                CFG_OTHER_HOLD:  r_other_th   <= w_cfg_th;
                CFG_LEVEL_STEP:  r_level_step <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in_valid && !o_in_stall) begin
            r_in_valid <= 1'b1;
        end else if (w_advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_key_code  <= i_key_code;
            r_is_repeat <= i_is_repeat;
            r_tick_time <= i_tick_time;
        end
    end

    always_comb begin
        w_class  = classify(r_key_code);
        w_updn   = (w_class.action == ACT_UP) || (w_class.action == ACT_DOWN);
        w_delta  = r_tick_time - r_last_time;
        if (w_updn) begin
            w_limit = r_updown_th;
        end else if (r_key_code == r_last_key) begin
            w_limit = r_same_th;
        end else begin
            w_limit = r_other_th;
        end
        w_acc = r_is_repeat ? w_updn : (CMP_W'(w_delta) >= CMP_W'(w_limit));

        n_chan_on    = r_chan_on;
        n_chan_level = r_chan_level;
        w_action     = w_class.action;
        w_ch         = 3'd0;
        w_adj        = 10'sd0;

        if (!w_acc) begin
            w_action = ACT_IGNORED;
        end else begin
            case (w_class.action)
                ACT_ALL_ON: begin
                    for (int i = 0; i < NUM_CHANNELS; i++) n_chan_on[i] = 1'b1;
                end
                ACT_ALL_OFF: begin
                    for (int i = 0; i < NUM_CHANNELS; i++) n_chan_on[i] = 1'b0;
                end
                ACT_TOGGLE, ACT_UP, ACT_DOWN: begin
                    if (w_class.slot == MASTER_SLOT) begin
                        w_ch = MASTER_CH;
                    end else if (4'(w_class.slot) < 4'(NUM_CHANNELS - 1)) begin
                        w_ch = w_class.slot;
                    end else begin
                        w_action = ACT_UNKNOWN;
                    end
                end
                default: ;
            endcase
        end

        w_idx = w_ch[IDX_W-1:0];
        if (w_action == ACT_TOGGLE) begin
            n_chan_on[w_idx] = !r_chan_on[w_idx];
        end else if (w_action == ACT_UP || w_action == ACT_DOWN) begin
            if (w_action == ACT_UP) begin
                w_adj = $signed({2'b00, r_chan_level[w_idx]})
                      + $signed({2'b00, r_level_step});
            end else begin
                w_adj = $signed({2'b00, r_chan_level[w_idx]})
                      - $signed({2'b00, r_level_step});
            end
            if (w_adj < $signed({2'b00, LEVEL_MIN})) begin
                n_chan_level[w_idx] = LEVEL_MIN;
            end else if (w_adj > $signed({2'b00, LEVEL_MAX})) begin
                n_chan_level[w_idx] = LEVEL_MAX;
            end else begin
                n_chan_level[w_idx] = w_adj[7:0];
            end
            n_chan_on[w_idx] = 1'b1;
        end

        w_mask = 6'd0;
        for (int i = 0; i < MASK_N; i++) w_mask[i] = n_chan_on[i];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_CHANNELS; i++) begin
                r_chan_on[i]    <= 1'b0;
                r_chan_level[i] <= LEVEL_MAX;
            end
            r_last_key  <= LAST_KEY_RESET;
            r_last_time <= 32'd0;
        end else if (w_advance) begin
            r_chan_on    <= n_chan_on;
            r_chan_level <= n_chan_level;
            if (w_acc && !r_is_repeat) begin
                r_last_key  <= r_key_code;
                r_last_time <= r_tick_time;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_accepted <= w_acc;
            r_action   <= w_action;
            r_channel  <= w_ch;
            r_on_mask  <= w_mask;
            r_level    <= n_chan_level[w_idx];
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_accepted  = r_accepted;
    assign o_action    = r_action;
    assign o_channel   = r_channel;
    assign o_on_mask   = r_on_mask;
    assign o_level     = r_level;

    a_accept_matches_action: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_accepted == (r_action != ACT_IGNORED)))
        else $error("accepted flag disagrees with action");

    a_level_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_level >= LEVEL_MIN && r_level <= LEVEL_MAX))
        else $error("result level outside 1..254");

    a_updown_forces_on: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_action == ACT_UP || r_action == ACT_DOWN) && r_channel < 3'd6)
        |-> r_on_mask[r_channel])
        else $error("up/down result leaves its channel off");

    a_idle_channel_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_action == ACT_IGNORED || r_action == ACT_UNKNOWN))
        |-> (r_channel == 3'd0))
        else $error("ignored or unknown result names a channel");

    a_input_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> r_in_valid)
        else $error("accepted input beat not held in input register");

endmodule

@@ dv/tb_top.sv @@
// Self-checking testbench for ir_key_dimmer_controller: directed key beats, then random
// key sequences under several debounce and step settings, checked against an in-bench model.
// Depends on irkd_pkg for the action and register-index types; drives the block's ports only.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import irkd_pkg::*;

    typedef struct packed {
        logic       acc;
        t_action    act;
        logic [2:0] ch;
        logic [5:0] mask;
        logic [7:0] lvl;
    } dimmer_result_t;

    typedef struct packed {
        logic [7:0]     key;
        logic           rep;
        logic [31:0]    tick;
        logic           typed;
        dimmer_result_t want;
    } key_beat_t;

    localparam int unsigned TICKS_MS = 16000;
    localparam int N_CH = 6;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 4;
    localparam int FLOOR_LVL = 1;
    localparam int CEIL_LVL = 254;
    localparam logic [7:0] ON_KEY = 8'h45;
    localparam logic [7:0] OFF_KEY = 8'h47;
    localparam logic [5:0][7:0] TOG_KEYS = {8'h42, 8'h08, 8'h0C, 8'h16, 8'h07, 8'h44};
    localparam logic [5:0][7:0] UP_KEYS = {8'h52, 8'h1C, 8'h18, 8'h19, 8'h15, 8'h40};
    localparam logic [5:0][7:0] DN_KEYS = {8'h4A, 8'h5A, 8'h5E, 8'h0D, 8'h09, 8'h43};

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_wr_en;
    t_cfg_reg    i_cfg_index;
    logic [15:0] i_cfg_data;
    logic        i_in_valid;
    logic        o_in_stall;
    logic [7:0]  i_key_code;
    logic        i_is_repeat;
    logic [31:0] i_tick_time;
    logic        o_out_valid;
    logic        i_out_stall;
    logic        o_accepted;
    t_action     o_action;
    logic [2:0]  o_channel;
    logic [5:0]  o_on_mask;
    logic [7:0]  o_level;

    logic [5:0]  lamp_on;
    logic [7:0]  lamp_lvl [N_CH];
    logic [7:0]  prev_key;
    logic [31:0] prev_tick;
    logic [15:0] hold_updown;
    logic [15:0] hold_same;
    logic [15:0] hold_other;
    logic [7:0]  lvl_step;

    dimmer_result_t results_q [$];
    int errors = 0;
    int cycles = 0;
    int beats_sent = 0;
    int results_seen = 0;
    int accepted_seen = 0;
    int settings_used = 1;
    int stall_left = 0;
    bit idle_on = 1'b1;
    bit long_hold_req = 1'b0;

    key_beat_t script [19] = '{
        '{ON_KEY, 1'b0, 32'd3_999_999, 1'b1, '{1'b0, ACT_IGNORED, 3'd0, 6'h00, 8'd254}},
        '{ON_KEY, 1'b0, 32'd4_000_000, 1'b1, '{1'b1, ACT_ALL_ON, 3'd0, 6'h3F, 8'd254}},
        '{ON_KEY, 1'b0, 32'd11_999_999, 1'b1, '{1'b0, ACT_IGNORED, 3'd0, 6'h3F, 8'd254}},
        '{ON_KEY, 1'b0, 32'd12_000_000, 1'b1, '{1'b1, ACT_ALL_ON, 3'd0, 6'h3F, 8'd254}},
        '{TOG_KEYS[0], 1'b1, 32'h0000_0000, 1'b1, '{1'b0, ACT_IGNORED, 3'd0, 6'h3F, 8'd254}},
        '{UP_KEYS[0], 1'b0, 32'd13_600_000, 1'b1, '{1'b1, ACT_UP, 3'd0, 6'h3F, 8'd254}},
        '{DN_KEYS[0], 1'b1, 32'h1234_5678, 1'b1, '{1'b1, ACT_DOWN, 3'd0, 6'h3F, 8'd242}},
        '{OFF_KEY, 1'b0, 32'd17_600_000, 1'b1, '{1'b1, ACT_ALL_OFF, 3'd0, 6'h00, 8'd242}},
        '{DN_KEYS[0], 1'b1, 32'hFFFF_FFFF, 1'b1, '{1'b1, ACT_DOWN, 3'd0, 6'h01, 8'd230}},
        '{TOG_KEYS[0], 1'b0, 32'd21_600_000, 1'b0, '0},
        '{TOG_KEYS[5], 1'b0, 32'd25_600_000, 1'b0, '0},
        '{UP_KEYS[2], 1'b1, 32'h8000_0000, 1'b0, '0},
        '{UP_KEYS[5], 1'b1, 32'h7FFF_FFFF, 1'b0, '0},
        '{DN_KEYS[4], 1'b1, 32'h0000_0001, 1'b0, '0},
        '{DN_KEYS[5], 1'b1, 32'hAAAA_5555, 1'b0, '0},
        '{8'h00, 1'b0, 32'd29_600_000, 1'b0, '0},
        '{8'h00, 1'b0, 32'd37_600_000, 1'b0, '0},
        '{8'hFF, 1'b1, 32'h5555_AAAA, 1'b0, '0},
        '{8'hFF, 1'b0, 32'h0000_0010, 1'b0, '0}
    };

    ir_key_dimmer_controller uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_key_code  (i_key_code),
        .i_is_repeat (i_is_repeat),
        .i_tick_time (i_tick_time),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_accepted  (o_accepted),
        .o_action    (o_action),
        .o_channel   (o_channel),
        .o_on_mask   (o_on_mask),
        .o_level     (o_level)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic void decode_key(input logic [7:0] key, output t_action op,
                                       output logic [2:0] slot);
        op = ACT_UNKNOWN;
        slot = 3'd0;
        if (key == ON_KEY) begin
            op = ACT_ALL_ON;
        end else if (key == OFF_KEY) begin
            op = ACT_ALL_OFF;
        end
        for (int s = 0; s < N_CH; s++) begin
            if (key == TOG_KEYS[s]) begin
                op = ACT_TOGGLE;
                slot = 3'(s);
            end else if (key == UP_KEYS[s]) begin
                op = ACT_UP;
                slot = 3'(s);
            end else if (key == DN_KEYS[s]) begin
                op = ACT_DOWN;
                slot = 3'(s);
            end
        end
    endfunction

    function automatic logic [15:0] hold_for(input logic [7:0] key, input t_action op);
        if (op == ACT_UP || op == ACT_DOWN) begin
            return hold_updown;
        end
        return (key == prev_key) ? hold_same : hold_other;
    endfunction

    function automatic dimmer_result_t step_dimmer(input key_beat_t b);
        dimmer_result_t r;
        t_action        op;
        logic [2:0]     slot;
        logic [31:0]    dt_ms;
        int             lvl;
        decode_key(b.key, op, slot);
        if (b.rep) begin
            r.acc = (op == ACT_UP || op == ACT_DOWN);
        end else begin
            dt_ms = (b.tick - prev_tick) / TICKS_MS;
            r.acc = dt_ms >= {16'd0, hold_for(b.key, op)};
            if (r.acc) begin
                prev_key = b.key;
                prev_tick = b.tick;
            end
        end
        r.ch = 3'd0;
        if (!r.acc) begin
            op = ACT_IGNORED;
        end else begin
            case (op)
                ACT_ALL_ON: lamp_on = '1;
                ACT_ALL_OFF: lamp_on = '0;
                ACT_TOGGLE: begin
                    r.ch = slot;
                    lamp_on[slot] = ~lamp_on[slot];
                end
                ACT_UP, ACT_DOWN: begin
                    r.ch = slot;
                    lvl = int'(lamp_lvl[slot]);
                    if (op == ACT_UP) begin
                        lvl = lvl + int'(lvl_step);
                    end else begin
                        lvl = lvl - int'(lvl_step);
                    end
                    if (lvl < FLOOR_LVL) lvl = FLOOR_LVL;
                    if (lvl > CEIL_LVL) lvl = CEIL_LVL;
                    lamp_lvl[slot] = 8'(lvl);
                    lamp_on[slot] = 1'b1;
                end
                default: ;
            endcase
        end
        r.act = op;
        r.mask = lamp_on;
        r.lvl = lamp_lvl[r.ch];
        return r;
    endfunction

    // Deltas cluster around the debounce boundary of the key's class, with some short
    // ones and some fully random ones so that the timestamp wraps often.
    function automatic key_beat_t random_beat();
        key_beat_t   b;
        t_action     op;
        logic [2:0]  slot;
        logic [31:0] bound;
        logic [31:0] delta;
        int          pick;
        int          k;
        pick = $urandom_range(0, 99);
        if (pick < 70) begin
            k = $urandom_range(0, 19);
            if (k == 0) begin
                b.key = ON_KEY;
            end else if (k == 1) begin
                b.key = OFF_KEY;
            end else if ((k - 2) % 3 == 0) begin
                b.key = TOG_KEYS[(k - 2) / 3];
            end else if ((k - 2) % 3 == 1) begin
                b.key = UP_KEYS[(k - 2) / 3];
            end else begin
                b.key = DN_KEYS[(k - 2) / 3];
            end
        end else if (pick < 85) begin
            b.key = prev_key;
        end else begin
            b.key = 8'($urandom);
        end
        b.rep = ($urandom_range(0, 3) == 0);
        decode_key(b.key, op, slot);
        bound = {16'd0, hold_for(b.key, op)} * TICKS_MS;
        case ($urandom_range(0, 5))
            0: delta = bound + $urandom_range(0, 15999);
            1: delta = bound - 32'd1 - $urandom_range(0, 15999);
            2: delta = $urandom;
            3: delta = $urandom_range(0, 20000);
            default: delta = bound + $urandom_range(0, 2000000);
        endcase
        b.tick = prev_tick + delta;
        b.typed = 1'b0;
        b.want = '0;
        return b;
    endfunction

    task automatic send_beat(input key_beat_t b);
        dimmer_result_t pred;
        i_in_valid <= 1'b1;
        i_key_code <= b.key;
        i_is_repeat <= b.rep;
        i_tick_time <= b.tick;
        do @(posedge i_clk); while (o_in_stall);
        pred = step_dimmer(b);
        results_q.push_back(b.typed ? b.want : pred);
        beats_sent++;
    endtask

    task automatic pause_sender();
        if (idle_on && $urandom_range(0, 99) < 12) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge i_clk);
        end
    endtask

    task automatic run_random(input int n);
        for (int i = 0; i < n; i++) begin
            pause_sender();
            send_beat(random_beat());
        end
    endtask

    // Waits until the block has drained, then rewrites all four registers.
    task automatic apply_settings(input logic [15:0] ud, input logic [15:0] same,
                                  input logic [15:0] other, input logic [7:0] step);
        i_in_valid <= 1'b0;
        while (results_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= CFG_UPDOWN_HOLD;
        i_cfg_data <= ud;
        @(posedge i_clk);
        i_cfg_index <= CFG_SAME_HOLD;
        i_cfg_data <= same;
        @(posedge i_clk);
        i_cfg_index <= CFG_OTHER_HOLD;
        i_cfg_data <= other;
        @(posedge i_clk);
        i_cfg_index <= CFG_LEVEL_STEP;
        i_cfg_data <= {8'($urandom), step};
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        hold_updown = ud;
        hold_same = same;
        hold_other = other;
        lvl_step = step;
        settings_used++;
    endtask

    initial begin
        i_out_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (stall_left > 0) begin
                stall_left--;
            end else if (long_hold_req) begin
                stall_left = 80;
                long_hold_req = 1'b0;
            end else if (idle_on && $urandom_range(0, 99) < 8) begin
                stall_left = $urandom_range(1, 19);
            end
            i_out_stall <= (stall_left > 0);
        end
    end

    always @(posedge i_clk) begin : result_check
        dimmer_result_t want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            results_seen++;
            if (results_q.size() == 0) begin
                $error("result beat arrived with nothing expected");
                errors++;
            end else begin
                want = results_q.pop_front();
                if (o_accepted !== want.acc) begin
                    $error("accepted: expected %0d, got %0d", want.acc, o_accepted);
                    errors++;
                end
                if (o_action !== want.act) begin
                    $error("action: expected %0d, got %0d", want.act, o_action);
                    errors++;
                end
                if (o_channel !== want.ch) begin
                    $error("channel: expected %0d, got %0d", want.ch, o_channel);
                    errors++;
                end
                if (o_on_mask !== want.mask) begin
                    $error("on_mask: expected 0x%02h, got 0x%02h", want.mask, o_on_mask);
                    errors++;
                end
                if (o_level !== want.lvl) begin
                    $error("level: expected %0d, got %0d", want.lvl, o_level);
                    errors++;
                end
                if (o_accepted === 1'b1) accepted_seen++;
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        i_rst_n <= 1'b0;
        i_cfg_wr_en <= 1'b0;
        i_cfg_index <= CFG_UPDOWN_HOLD;
        i_cfg_data <= '0;
        i_in_valid <= 1'b0;
        i_key_code <= '0;
        i_is_repeat <= 1'b0;
        i_tick_time <= '0;
        lamp_on = '0;
        foreach (lamp_lvl[i]) lamp_lvl[i] = 8'd254;
        prev_key = 8'hFF;
        prev_tick = '0;
        hold_updown = 16'd100;
        hold_same = 16'd500;
        hold_other = 16'd250;
        lvl_step = 8'd12;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (script[i]) begin
            pause_sender();
            send_beat(script[i]);
        end
        run_random(120);

        apply_settings(16'd0, 16'd0, 16'd0, 8'd253);
        run_random(100);
        apply_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 8'd1);
        run_random(80);
        apply_settings(16'd5, 16'd40, 16'd20, 8'd0);
        run_random(80);
        apply_settings(16'd50, 16'd300, 16'd150, 8'd255);
        run_random(80);
        apply_settings(16'($urandom_range(0, 1000)), 16'($urandom_range(0, 1000)),
                       16'($urandom_range(0, 1000)), 8'($urandom_range(1, 253)));
        long_hold_req = 1'b1;
        run_random(120);
        apply_settings(16'd100, 16'd500, 16'd250, 8'd12);
        idle_on = 1'b0;
        run_random(120);

        i_in_valid <= 1'b0;
        while (results_q.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        $display("Sent %0d key beats under %0d register settings; %0d results checked, %0d accepted.",
                 beats_sent, settings_used, results_seen, accepted_seen);
        if (errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end
endmodule
